### src/psd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// psd_pkg: shared types, constants and microcode for the step detector
// Register map, control word layout, datapath operations and the program ROM.
// ----------------------------------------------------------------------------
package psd_pkg;

   localparam int FRAC_BITS_DEF = 16;

   localparam int PC_W  = 5;
   localparam int CNT_W = 4;
   // 16 passes through a loop step: counter loaded with 15, loops until zero
   localparam logic [CNT_W-1:0] LOOP_LAST = 4'd15;

   localparam logic [15:0] CADENCE_NUM = 16'd60000;
   localparam logic [15:0] MAG_ONE_G   = 16'd4096;
   localparam logic [31:0] SQRT_TOP    = 32'h4000_0000;

   localparam int REQ_DATA_W = 80;
   localparam int RSP_DATA_W = 48;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 16;

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_STEP_THR  = 3'd0,
      CSR_REL_THR   = 3'd1,
      CSR_MIN_INT   = 3'd2,
      CSR_IDLE_TO   = 3'd3,
      CSR_RHY_WIN   = 3'd4,
      CSR_WARMUP    = 3'd5,
      CSR_RUN_CAD   = 3'd6,
      CSR_FILT_COEF = 3'd7
   } csr_idx_type;

   typedef enum logic [1:0] {
      MOTION_STATIONARY = 2'd0,
      MOTION_ACTIVE     = 2'd1,
      MOTION_WALKING    = 2'd2,
      MOTION_RUNNING    = 2'd3
   } motion_type;

   typedef enum logic [4:0] {
      OP_NOP     = 5'd0,
      OP_MULX    = 5'd1,
      OP_MULY    = 5'd2,
      OP_MULZ    = 5'd3,
      OP_SQINIT  = 5'd4,
      OP_SQSTEP  = 5'd5,
      OP_DIFF    = 5'd6,
      OP_PLO     = 5'd7,
      OP_PHI     = 5'd8,
      OP_DELTA   = 5'd9,
      OP_GRAV    = 5'd10,
      OP_FLAGS   = 5'd11,
      OP_STEP    = 5'd12,
      OP_RUN     = 5'd13,
      OP_DIVSTEP = 5'd14,
      OP_CAD     = 5'd15,
      OP_NORHY   = 5'd16,
      OP_NOSTEP  = 5'd17,
      OP_OUT     = 5'd18,
      OP_CLR     = 5'd19
   } op_type;

   typedef enum logic [2:0] {
      C_NEXT    = 3'd0,
      C_ALWAYS  = 3'd1,
      C_NOGO    = 3'd2,
      C_FUNC    = 3'd3,
      C_LOOP    = 3'd4,
      C_NOSTEP  = 3'd5,
      C_NORHY   = 3'd6,
      C_OUTBUSY = 3'd7
   } cond_type;

   typedef struct packed {
      op_type          op;
      cond_type        cond;
      logic [PC_W-1:0] target;
      logic            ld_cnt;
   } ctl_type;

   typedef struct packed {
      logic go;
      logic func;
      logic step_hit;
      logic rhythmic;
      logic out_busy;
   } stat_type;

   typedef struct packed {
      logic func;
      logic step_hit;
      logic rhythmic;
   } dflag_type;

   typedef struct packed {
      logic [15:0] step_thr;
      logic [15:0] rel_thr;
      logic [15:0] min_int;
      logic [15:0] idle_to;
      logic [15:0] rhy_win;
      logic [7:0]  warmup;
      logic [7:0]  run_cad;
      logic [15:0] coef;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      step_thr: 16'd1147, rel_thr: 16'd614, min_int: 16'd300, idle_to: 16'd2000,
      rhy_win: 16'd1500, warmup: 8'd2, run_cad: 8'd145, coef: 16'd5243};

   // total in the low bits, step_seen on top
   typedef struct packed {
      logic        step_seen;
      motion_type  motion;
      logic [7:0]  cadence;
      logic [31:0] total;
   } rsp_type;

   // program labels
   localparam logic [PC_W-1:0] L_WAIT    = 5'd0;
   localparam logic [PC_W-1:0] L_SQLOOP  = 5'd5;
   localparam logic [PC_W-1:0] L_DIVLOOP = 5'd16;
   localparam logic [PC_W-1:0] L_NORHY   = 5'd18;
   localparam logic [PC_W-1:0] L_NOSTEP  = 5'd19;
   localparam logic [PC_W-1:0] L_OUT     = 5'd20;
   localparam logic [PC_W-1:0] L_CLR     = 5'd22;

   // microcode ROM: condition true -> target, else next address
   function automatic ctl_type ucode(input logic [PC_W-1:0] pc);
      ctl_type w;
      w = '{OP_NOP, C_ALWAYS, L_WAIT, 1'b0};
      case (pc)
         5'd0:  w = '{OP_NOP,     C_NOGO,    L_WAIT,    1'b0};
         5'd1:  w = '{OP_MULX,    C_FUNC,    L_CLR,     1'b0};
         5'd2:  w = '{OP_MULY,    C_NEXT,    L_WAIT,    1'b0};
         5'd3:  w = '{OP_MULZ,    C_NEXT,    L_WAIT,    1'b0};
         5'd4:  w = '{OP_SQINIT,  C_NEXT,    L_WAIT,    1'b1};
         5'd5:  w = '{OP_SQSTEP,  C_LOOP,    L_SQLOOP,  1'b0};
         5'd6:  w = '{OP_DIFF,    C_NEXT,    L_WAIT,    1'b0};
         5'd7:  w = '{OP_PLO,     C_NEXT,    L_WAIT,    1'b0};
         5'd8:  w = '{OP_PHI,     C_NEXT,    L_WAIT,    1'b0};
         5'd9:  w = '{OP_DELTA,   C_NEXT,    L_WAIT,    1'b0};
         5'd10: w = '{OP_GRAV,    C_NEXT,    L_WAIT,    1'b0};
         5'd11: w = '{OP_DIFF,    C_NEXT,    L_WAIT,    1'b0};
         5'd12: w = '{OP_FLAGS,   C_NEXT,    L_WAIT,    1'b0};
         5'd13: w = '{OP_NOP,     C_NOSTEP,  L_NOSTEP,  1'b0};
         5'd14: w = '{OP_STEP,    C_NORHY,   L_NORHY,   1'b0};
         5'd15: w = '{OP_RUN,     C_NEXT,    L_WAIT,    1'b1};
         5'd16: w = '{OP_DIVSTEP, C_LOOP,    L_DIVLOOP, 1'b0};
         5'd17: w = '{OP_CAD,     C_ALWAYS,  L_OUT,     1'b0};
         5'd18: w = '{OP_NORHY,   C_ALWAYS,  L_OUT,     1'b0};
         5'd19: w = '{OP_NOSTEP,  C_NEXT,    L_WAIT,    1'b0};
         5'd20: w = '{OP_OUT,     C_OUTBUSY, L_OUT,     1'b0};
         5'd21: w = '{OP_NOP,     C_ALWAYS,  L_WAIT,    1'b0};
         5'd22: w = '{OP_CLR,     C_ALWAYS,  L_OUT,     1'b0};
         default: w = '{OP_NOP,   C_ALWAYS,  L_WAIT,    1'b0};
      endcase
      return w;
   endfunction

endpackage
`default_nettype wire

### src/pedometer_step_detector.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pedometer_step_detector: accelerometer step counter, top level
// Microcoded sequencer driving a shared datapath; one result word per sample.
// ----------------------------------------------------------------------------
// Usage:
//  - req_ channel takes one word per sample: tuser selects a normal sample (0)
//    or a clear of all step state (1); tdata holds x, y, z and the ms time.
//  - rsp_ channel returns one word per request: step total, cadence, motion
//    class and the step flag.
//  - csr_ port writes a tuning register; write only while idle.
//  - Only a rhythmic step runs the divide loop; a sample without one skips
//    it, and a clear skips the whole sample path. A new word is taken only
//    after the result is registered and the sequencer is back in wait.
//  - The microprogram holds two 16-pass loops: the bit-pair square root and
//    the restoring divide for 60000 / interval.
//  - req_tready is high only while the sequencer sits in its wait step.
//  - A stalled receiver holds the result register; the sequencer waits in
//    its output step until the register frees up, then returns to wait.
//  - Reset loads register defaults, gravity to 1 g and clears step state.
// ----------------------------------------------------------------------------
module pedometer_step_detector #(
   parameter int FILTER_FRAC_BITS = psd_pkg::FRAC_BITS_DEF
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   // request channel
   input  wire logic                             req_tvalid,
   output logic                                  req_tready,
   // tdata: accel_x[15:0], accel_y[31:16], accel_z[47:32], time_ms[79:48]
   input  wire logic [psd_pkg::REQ_DATA_W-1:0]   req_tdata,
   // tuser: func[0]
   input  wire logic                             req_tuser,
   // response channel
   output logic                                  rsp_tvalid,
   input  wire logic                             rsp_tready,
   // tdata: total_steps[31:0], cadence[39:32], motion_class[41:40],
   //        step_seen[42], zero[47:43]
   output logic [psd_pkg::RSP_DATA_W-1:0]        rsp_tdata,
   // register write port
   input  wire logic                             csr_we,
   input  wire logic [psd_pkg::CSR_ADDR_W-1:0]   csr_addr,
   input  wire logic [psd_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   localparam int RSP_PAD = psd_pkg::RSP_DATA_W - $bits(psd_pkg::rsp_type);

   psd_pkg::cfg_type   cfg_ff, cfg_in;
   psd_pkg::ctl_type   ctl;
   psd_pkg::stat_type  stat;
   psd_pkg::dflag_type dflags;
   psd_pkg::rsp_type   dp_rsp;
   psd_pkg::rsp_type   rsp_q_ff;
   logic               rsp_tvalid_ff, rsp_tvalid_in;
   logic               seq_idle;
   logic               accept;
   logic               out_busy;
   logic               out_load;

   // ---- tuning registers ----
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (psd_pkg::csr_idx_type'(csr_addr))
            psd_pkg::CSR_STEP_THR:  cfg_in.step_thr = csr_wdata;
            psd_pkg::CSR_REL_THR:   cfg_in.rel_thr  = csr_wdata;
            psd_pkg::CSR_MIN_INT:   cfg_in.min_int  = csr_wdata;
            psd_pkg::CSR_IDLE_TO:   cfg_in.idle_to  = csr_wdata;
            psd_pkg::CSR_RHY_WIN:   cfg_in.rhy_win  = csr_wdata;
            psd_pkg::CSR_WARMUP:    cfg_in.warmup   = csr_wdata[7:0];
            psd_pkg::CSR_RUN_CAD:   cfg_in.run_cad  = csr_wdata[7:0];
            psd_pkg::CSR_FILT_COEF: cfg_in.coef     = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= psd_pkg::CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // ---- handshake ----
   assign req_tready = seq_idle;
   assign accept     = req_tvalid && req_tready;
   assign out_busy   = rsp_tvalid_ff && !rsp_tready;
   assign out_load   = (ctl.op == psd_pkg::OP_OUT) && !out_busy;

   always_comb begin
      stat.go       = accept;
      stat.func     = dflags.func;
      stat.step_hit = dflags.step_hit;
      stat.rhythmic = dflags.rhythmic;
      stat.out_busy = out_busy;
   end

   // ---- sequencer and datapath ----
   psd_useq u_useq (
      .clock (clock),
      .reset (reset),
      .stat  (stat),
      .ctl   (ctl),
      .idle  (seq_idle)
   );

   psd_dpath #(
      .FRAC_BITS (FILTER_FRAC_BITS)
   ) u_dpath (
      .clock   (clock),
      .reset   (reset),
      .load    (accept),
      .in_func (req_tuser),
      .in_x    ($signed(req_tdata[15:0])),
      .in_y    ($signed(req_tdata[31:16])),
      .in_z    ($signed(req_tdata[47:32])),
      .in_time (req_tdata[79:48]),
      .cfg     (cfg_ff),
      .op      (ctl.op),
      .flags   (dflags),
      .rsp     (dp_rsp)
   );

   // ---- result register ----
   always_comb begin
      rsp_tvalid_in = rsp_tvalid_ff;
      if (out_load) begin
         rsp_tvalid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_tvalid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else begin
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_q_ff <= dp_rsp;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = {{RSP_PAD{1'b0}}, rsp_q_ff};

`ifndef ASSERT_OFF
   // one word in flight: an accepted word takes the sequencer out of wait
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("request accepted while a word is in flight");

   // a nonzero cadence only comes with walking or running
   a_cad_motion: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_q_ff.cadence != 8'd0) |->
      (rsp_q_ff.motion == psd_pkg::MOTION_WALKING ||
       rsp_q_ff.motion == psd_pkg::MOTION_RUNNING))
      else $error("cadence set without walking or running");

   // the output step loads the register and raises valid
   a_out_load: assert property (@(posedge clock) disable iff (reset)
      out_load |=> rsp_tvalid)
      else $error("result loaded without valid");
`endif

endmodule
`default_nettype wire

### src/psd_useq.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// psd_useq: microcode sequencer
// Program counter, loop counter and conditional jumps over the control ROM.
// ----------------------------------------------------------------------------
module psd_useq (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire psd_pkg::stat_type  stat,
   output psd_pkg::ctl_type        ctl,
   output logic                    idle
);

   logic [psd_pkg::PC_W-1:0]  pc_ff, pc_in;
   logic [psd_pkg::CNT_W-1:0] cnt_ff, cnt_in;
   logic                      take;

   always_comb begin
      ctl = psd_pkg::ucode(pc_ff);
   end

   always_comb begin
      case (ctl.cond)
         psd_pkg::C_NEXT:    take = 1'b0;
         psd_pkg::C_ALWAYS:  take = 1'b1;
         psd_pkg::C_NOGO:    take = !stat.go;
         psd_pkg::C_FUNC:    take = stat.func;
         psd_pkg::C_LOOP:    take = (cnt_ff != '0);
         psd_pkg::C_NOSTEP:  take = !stat.step_hit;
         psd_pkg::C_NORHY:   take = !stat.rhythmic;
         psd_pkg::C_OUTBUSY: take = stat.out_busy;
         default:            take = 1'b0;
      endcase
      pc_in  = take ? ctl.target : pc_ff + 1'b1;
      cnt_in = cnt_ff;
      if (ctl.ld_cnt) begin
         cnt_in = psd_pkg::LOOP_LAST;
      end else if (ctl.cond == psd_pkg::C_LOOP && cnt_ff != '0) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff  <= psd_pkg::L_WAIT;
         cnt_ff <= '0;
      end else begin
         pc_ff  <= pc_in;
         cnt_ff <= cnt_in;
      end
   end

   assign idle = (pc_ff == psd_pkg::L_WAIT);

endmodule
`default_nettype wire

### src/psd_dpath.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// psd_dpath: step detector datapath
// Squares, bit-pair square root, gravity filter, step decision, cadence divide.
// ----------------------------------------------------------------------------
module psd_dpath #(
   parameter int FRAC_BITS = psd_pkg::FRAC_BITS_DEF
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               load,
   input  wire logic               in_func,
   input  wire logic signed [15:0] in_x,
   input  wire logic signed [15:0] in_y,
   input  wire logic signed [15:0] in_z,
   input  wire logic [31:0]        in_time,
   input  wire psd_pkg::cfg_type   cfg,
   input  wire psd_pkg::op_type    op,
   output psd_pkg::dflag_type      flags,
   output psd_pkg::rsp_type        rsp
);

   localparam logic [31:0] GRAV_RESET = 32'(psd_pkg::MAG_ONE_G) << FRAC_BITS;

   // captured word
   logic               func_ff;
   logic signed [15:0] ax_ff, ay_ff, az_ff;
   logic [31:0]        now_ff;

   // scratch
   logic [30:0]        mreg_ff, mreg_in;
   logic [31:0]        sum_ff, sum_in;
   logic [31:0]        sqv_ff, sqv_in;
   logic [31:0]        res_ff, res_in;
   logic [31:0]        sqbit_ff, sqbit_in;
   logic signed [32:0] diff_ff, diff_in;
   logic [32:0]        plo_ff, plo_in;
   logic signed [32:0] phi_ff, phi_in;
   logic [31:0]        delta_ff, delta_in;
   logic [31:0]        dt_ff, dt_in;
   logic               hit_ff, hit_in;
   logic               rhy_ff, rhy_in;
   logic               idle_ff, idle_in;
   logic               below_ff, below_in;
   logic               absbel_ff, absbel_in;
   logic [15:0]        dvd_ff, dvd_in;
   logic [15:0]        rem_ff, rem_in;
   logic [15:0]        quo_ff, quo_in;

   // architectural state
   logic [31:0]         grav_ff, grav_in;
   logic [31:0]         total_ff, total_in;
   logic [31:0]         last_ff, last_in;
   logic                has_ff, has_in;
   logic                armed_ff, armed_in;
   logic [7:0]          run_ff, run_in;
   logic [7:0]          cad_ff, cad_in;
   psd_pkg::motion_type motion_ff, motion_in;
   logic                seen_ff, seen_in;

   // helpers
   logic signed [15:0] mop;
   logic signed [31:0] sq;
   logic [31:0]        magq, thrq, relq, sq_t;
   logic signed [32:0] diff_calc;
   logic signed [16:0] coef_s;
   logic signed [15:0] dh_s;
   logic [49:0]        prod;
   logic signed [33:0] dyn34, thr34, rel34, nrel34;
   logic [16:0]        rem_sh;
   logic               rem_ge;
   logic [7:0]         run_inc, q8, cad_new;

   always_comb begin
      case (op)
         psd_pkg::OP_MULX: mop = ax_ff;
         psd_pkg::OP_MULY: mop = ay_ff;
         default:          mop = az_ff;
      endcase
      sq        = mop * mop;
      magq      = 32'(res_ff[15:0]) << FRAC_BITS;
      thrq      = 32'(cfg.step_thr) << FRAC_BITS;
      relq      = 32'(cfg.rel_thr) << FRAC_BITS;
      diff_calc = $signed({1'b0, magq}) - $signed({1'b0, grav_ff});
      sq_t      = res_ff + sqbit_ff;
      coef_s    = $signed({1'b0, cfg.coef});
      dh_s      = $signed(diff_ff[32:17]);
      prod      = {phi_ff, 17'b0} + {17'b0, plo_ff};
      dyn34     = {diff_ff[32], diff_ff};
      thr34     = $signed({2'b0, thrq});
      rel34     = $signed({2'b0, relq});
      nrel34    = -rel34;
      rem_sh    = {rem_ff, dvd_ff[15]};
      rem_ge    = (32'(rem_sh) >= dt_ff);
      run_inc   = (run_ff == 8'hFF) ? 8'hFF : run_ff + 8'd1;
      q8        = (quo_ff[15:8] != 8'd0) ? 8'hFF : quo_ff[7:0];
      cad_new   = (dt_ff == 32'd0) ? 8'd0 : q8;
   end

   always_comb begin
      mreg_in   = mreg_ff;
      sum_in    = sum_ff;
      sqv_in    = sqv_ff;
      res_in    = res_ff;
      sqbit_in  = sqbit_ff;
      diff_in   = diff_ff;
      plo_in    = plo_ff;
      phi_in    = phi_ff;
      delta_in  = delta_ff;
      dt_in     = dt_ff;
      hit_in    = hit_ff;
      rhy_in    = rhy_ff;
      idle_in   = idle_ff;
      below_in  = below_ff;
      absbel_in = absbel_ff;
      dvd_in    = dvd_ff;
      rem_in    = rem_ff;
      quo_in    = quo_ff;
      grav_in   = grav_ff;
      total_in  = total_ff;
      last_in   = last_ff;
      has_in    = has_ff;
      armed_in  = armed_ff;
      run_in    = run_ff;
      cad_in    = cad_ff;
      motion_in = motion_ff;
      seen_in   = seen_ff;
      case (op)
         psd_pkg::OP_MULX: begin
            mreg_in = sq[30:0];
            seen_in = 1'b0;
         end
         psd_pkg::OP_MULY: begin
            sum_in  = 32'(mreg_ff);
            mreg_in = sq[30:0];
         end
         psd_pkg::OP_MULZ: begin
            sum_in  = sum_ff + 32'(mreg_ff);
            mreg_in = sq[30:0];
         end
         psd_pkg::OP_SQINIT: begin
            sqv_in   = sum_ff + 32'(mreg_ff);
            res_in   = '0;
            sqbit_in = psd_pkg::SQRT_TOP;
         end
         psd_pkg::OP_SQSTEP: begin
            if (sqv_ff >= sq_t) begin
               sqv_in = sqv_ff - sq_t;
               res_in = (res_ff >> 1) + sqbit_ff;
            end else begin
               res_in = res_ff >> 1;
            end
            sqbit_in = sqbit_ff >> 2;
         end
         psd_pkg::OP_DIFF: diff_in = diff_calc;
         // coef * diff split at bit 17: low part unsigned, high part signed
         psd_pkg::OP_PLO:  plo_in = 33'(cfg.coef) * 33'(diff_ff[16:0]);
         psd_pkg::OP_PHI:  phi_in = coef_s * dh_s;
         // floor(prod / 2^16), kept modulo 2^32
         psd_pkg::OP_DELTA: delta_in = prod[47:16];
         psd_pkg::OP_GRAV: begin
            grav_in = grav_ff + delta_ff;
            dt_in   = now_ff - last_ff;
         end
         psd_pkg::OP_FLAGS: begin
            idle_in   = !has_ff || (dt_ff > 32'(cfg.idle_to));
            hit_in    = armed_ff && (dyn34 > thr34)
                        && (!has_ff || dt_ff >= 32'(cfg.min_int));
            rhy_in    = has_ff && (dt_ff <= 32'(cfg.rhy_win));
            below_in  = (dyn34 < rel34);
            absbel_in = (dyn34 < rel34) && (dyn34 > nrel34);
         end
         psd_pkg::OP_STEP: begin
            last_in  = now_ff;
            has_in   = 1'b1;
            armed_in = 1'b0;
            seen_in  = 1'b1;
         end
         psd_pkg::OP_RUN: begin
            run_in = run_inc;
            if (run_ff < cfg.warmup && run_inc == cfg.warmup) begin
               total_in = total_ff + 32'(cfg.warmup);
            end else if (run_ff >= cfg.warmup) begin
               total_in = total_ff + 32'd1;
            end
            dvd_in = psd_pkg::CADENCE_NUM;
            rem_in = '0;
            quo_in = '0;
         end
         psd_pkg::OP_DIVSTEP: begin
            if (rem_ge) begin
               rem_in = 16'(rem_sh - dt_ff[16:0]);
               quo_in = {quo_ff[14:0], 1'b1};
            end else begin
               rem_in = rem_sh[15:0];
               quo_in = {quo_ff[14:0], 1'b0};
            end
            dvd_in = dvd_ff << 1;
         end
         psd_pkg::OP_CAD: begin
            cad_in    = cad_new;
            motion_in = (cad_new >= cfg.run_cad) ? psd_pkg::MOTION_RUNNING
                                                 : psd_pkg::MOTION_WALKING;
         end
         psd_pkg::OP_NORHY: begin
            run_in    = 8'd1;
            cad_in    = 8'd0;
            motion_in = psd_pkg::MOTION_ACTIVE;
         end
         psd_pkg::OP_NOSTEP: begin
            if (!armed_ff && (below_ff || idle_ff)) begin
               armed_in = 1'b1;
            end
            if (idle_ff) begin
               run_in    = 8'd0;
               cad_in    = 8'd0;
               motion_in = absbel_ff ? psd_pkg::MOTION_STATIONARY
                                     : psd_pkg::MOTION_ACTIVE;
            end
         end
         psd_pkg::OP_CLR: begin
            grav_in   = GRAV_RESET;
            total_in  = '0;
            last_in   = '0;
            has_in    = 1'b0;
            armed_in  = 1'b1;
            run_in    = '0;
            cad_in    = '0;
            motion_in = psd_pkg::MOTION_STATIONARY;
            seen_in   = 1'b0;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         grav_ff   <= GRAV_RESET;
         total_ff  <= '0;
         last_ff   <= '0;
         has_ff    <= 1'b0;
         armed_ff  <= 1'b1;
         run_ff    <= '0;
         cad_ff    <= '0;
         motion_ff <= psd_pkg::MOTION_STATIONARY;
         seen_ff   <= 1'b0;
      end else begin
         grav_ff   <= grav_in;
         total_ff  <= total_in;
         last_ff   <= last_in;
         has_ff    <= has_in;
         armed_ff  <= armed_in;
         run_ff    <= run_in;
         cad_ff    <= cad_in;
         motion_ff <= motion_in;
         seen_ff   <= seen_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         func_ff <= in_func;
         ax_ff   <= in_x;
         ay_ff   <= in_y;
         az_ff   <= in_z;
         now_ff  <= in_time;
      end
      mreg_ff   <= mreg_in;
      sum_ff    <= sum_in;
      sqv_ff    <= sqv_in;
      res_ff    <= res_in;
      sqbit_ff  <= sqbit_in;
      diff_ff   <= diff_in;
      plo_ff    <= plo_in;
      phi_ff    <= phi_in;
      delta_ff  <= delta_in;
      dt_ff     <= dt_in;
      hit_ff    <= hit_in;
      rhy_ff    <= rhy_in;
      idle_ff   <= idle_in;
      below_ff  <= below_in;
      absbel_ff <= absbel_in;
      dvd_ff    <= dvd_in;
      rem_ff    <= rem_in;
      quo_ff    <= quo_in;
   end

   assign flags.func     = func_ff;
   assign flags.step_hit = hit_ff;
   assign flags.rhythmic = rhy_ff;

   assign rsp.step_seen = seen_ff;
   assign rsp.motion    = motion_ff;
   assign rsp.cadence   = cad_ff;
   assign rsp.total     = total_ff;

endmodule
`default_nettype wire

### bench/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for pedometer_step_detector
// Drives sample and clear words, tunes the detector between phases, and
// checks every result word, typed in or from a cycle-free step counter model.
// ----------------------------------------------------------------------------
// Flow:
//  - A directed plan comes first: rest and extreme vectors, a clear, the
//    minimum interval gate, warm-up credit, walking vs running, a time wrap,
//    a zero interval and a saturated cadence. Rows whose result is plain at
//    a glance carry it typed in; the rest go through the model.
//  - Thirteen random blocks follow. Most words are a synthetic gait (a 1 g
//    baseline with periodic lifts); the rest are clears, raw noise, long
//    pauses and jumps to just before the ms counter wraps. Blocks 3 to 8 run
//    a dense gait under a wide rhythm window so the run counter saturates.
//  - Before each block the sender holds off until every result is back; the
//    tuning registers are rewritten, extremes included, except before 4 to 8.
//  - Idle patterns rotate per block: none, sender gaps, receiver stalls, both.
// ----------------------------------------------------------------------------
module testbench;
   import psd_pkg::*;

   localparam int          FRAC        = FRAC_BITS_DEF;
   localparam logic [31:0] SPM_NUM     = 32'd60000;  // ms per minute
   localparam int          LIMIT_CYC   = 600_000;
   localparam int          N_BLOCKS    = 13;
   localparam int          BLOCK_WORDS = 100;
   localparam int          MAX_REPORTS = 10;

   typedef enum logic { ROW_WORD, ROW_TUNE } row_kind_e;

   // one directed step: either a request word or a single register change
   typedef struct packed {
      row_kind_e   kind;
      csr_idx_type reg_sel;
      logic [15:0] reg_val;
      logic        clr;
      logic [15:0] ax;
      logic [15:0] ay;
      logic [15:0] az;
      logic [31:0] tms;
      logic        typed;   // want holds the result as read off by hand
      rsp_type     want;
   } plan_row_t;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   // tdata: accel_x[15:0], accel_y[31:16], accel_z[47:32], time_ms[79:48]
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   // tuser: func[0]
   logic                  req_tuser  = 1'b0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   // tdata: total_steps[31:0], cadence[39:32], motion_class[41:40],
   //        step_seen[42], zero[47:43]
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_we     = 1'b0;
   csr_idx_type           csr_addr   = CSR_STEP_THR;
   logic [CSR_DATA_W-1:0] csr_wdata  = '0;

   // idle odds in percent, set per phase
   int send_idle_pct  = 0;
   int recv_stall_pct = 0;

   int error_count = 0;
   int cycle_count = 0;

   // results still owed by the block, oldest first
   rsp_type due_words[$];

   // model copy of the tuning registers and the detector state
   cfg_type     tuning = CFG_RESET;
   logic [31:0] grav_q;
   logic [31:0] steps_total;
   logic [31:0] last_step_ms;
   logic        step_valid;
   logic        armed;
   logic [7:0]  rhythm_len;
   logic [7:0]  cadence_spm;
   motion_type  track_motion;

   // synthetic gait
   logic [31:0] walk_ms   = 32'h0000_0400;
   int          gait_period = 600;
   int          gait_phase  = 0;
   int          gait_lift   = 3000;
   logic        dense_peak  = 1'b0;

   plan_row_t plan[$];

   pedometer_step_detector u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // ---------------------------------------------------------------------
   // Step counter model
   // ---------------------------------------------------------------------
   function automatic void reset_tracker();
      grav_q       = 32'(MAG_ONE_G) << FRAC;
      steps_total  = '0;
      last_step_ms = '0;
      step_valid   = 1'b0;
      armed        = 1'b1;
      rhythm_len   = '0;
      cadence_spm  = '0;
      track_motion = MOTION_STATIONARY;
   endfunction

   // advance the model by one word and return the result it owes
   function automatic rsp_type track_step(input logic clr, input logic [15:0] ax,
                                          input logic [15:0] ay, input logic [15:0] az,
                                          input logic [31:0] now_ms);
      rsp_type     r;
      longint      sx, sy, sz, sum_l;
      logic [31:0] energy;
      logic [15:0] root, trial;
      longint      mag_q, err, delta, dyn, dyn_abs, thr_q, rel_q;
      logic [31:0] dt, quot;
      logic        idle, hit;
      logic [7:0]  prev_run;
      hit = 1'b0;
      if (clr) begin
         reset_tracker();
      end else begin
         sx = $signed(ax);
         sy = $signed(ay);
         sz = $signed(az);
         sum_l  = sx * sx + sy * sy + sz * sz;
         energy = sum_l[31:0];
         // floor square root, one result bit per pass
         root = '0;
         for (int b = 15; b >= 0; b--) begin
            trial = root | (16'd1 << b);
            if (longint'(trial) * longint'(trial) <= longint'(energy))
               root = trial;
         end
         mag_q  = longint'(root) << FRAC;
         err    = mag_q - longint'(grav_q);
         delta  = (longint'(tuning.coef) * err) >>> 16;   // floor
         grav_q = 32'(longint'(grav_q) + delta);
         dyn    = mag_q - longint'(grav_q);
         thr_q  = longint'(tuning.step_thr) << FRAC;
         rel_q  = longint'(tuning.rel_thr) << FRAC;
         dt     = now_ms - last_step_ms;
         idle   = !step_valid || dt > 32'(tuning.idle_to);

         if (armed && dyn > thr_q && (!step_valid || dt >= 32'(tuning.min_int))) begin
            if (step_valid && dt <= 32'(tuning.rhy_win)) begin
               prev_run   = rhythm_len;
               rhythm_len = (prev_run != 8'd255) ? prev_run + 8'd1 : 8'd255;
               // warm-up credit lands once, then one per step
               if (prev_run < tuning.warmup && rhythm_len == tuning.warmup)
                  steps_total += 32'(tuning.warmup);
               else if (prev_run >= tuning.warmup)
                  steps_total += 32'd1;
               quot         = (dt != 0) ? SPM_NUM / dt : 32'd0;
               cadence_spm  = (quot > 32'd255) ? 8'd255 : quot[7:0];
               track_motion = (cadence_spm >= tuning.run_cad) ? MOTION_RUNNING
                                                              : MOTION_WALKING;
            end else begin
               rhythm_len   = 8'd1;
               cadence_spm  = '0;
               track_motion = MOTION_ACTIVE;
            end
            last_step_ms = now_ms;
            step_valid   = 1'b1;
            armed        = 1'b0;
            hit          = 1'b1;
         end else begin
            if (!armed && (dyn < rel_q || idle))
               armed = 1'b1;
            if (idle) begin
               dyn_abs      = (dyn < 0) ? -dyn : dyn;
               rhythm_len   = '0;
               cadence_spm  = '0;
               track_motion = (dyn_abs < rel_q) ? MOTION_STATIONARY : MOTION_ACTIVE;
            end
         end
      end
      r.total     = steps_total;
      r.cadence   = cadence_spm;
      r.motion    = track_motion;
      r.step_seen = hit;
      return r;
   endfunction

   // ---------------------------------------------------------------------
   // Request side
   // ---------------------------------------------------------------------
   // called at a rising edge; returns at the edge that took the word
   task automatic send_word(input logic clr, input logic [15:0] ax, input logic [15:0] ay,
                            input logic [15:0] az, input logic [31:0] tms,
                            input logic typed, input rsp_type want);
      rsp_type pred;
      logic    taken;
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= clr;
      req_tdata  <= {tms, az, ay, ax};
      // tready is settled by the falling edge; the next rising edge takes it
      do begin
         @(negedge clock);
         taken = req_tready;
         @(posedge clock);
      end while (!taken);
      pred = track_step(clr, ax, ay, az, tms);
      due_words.push_back(typed ? want : pred);
   endtask

   // hold off until every owed word is back and the sequencer is waiting
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (due_words.size() != 0)
         @(posedge clock);
      do @(negedge clock); while (!req_tready);
      @(posedge clock);
   endtask

   // rewrite all eight registers; 8-bit ones get junk in the upper byte
   task automatic load_tuning(input cfg_type c);
      logic [15:0] word;
      for (int i = 0; i < 8; i++) begin
         case (csr_idx_type'(i))
            CSR_STEP_THR:  word = c.step_thr;
            CSR_REL_THR:   word = c.rel_thr;
            CSR_MIN_INT:   word = c.min_int;
            CSR_IDLE_TO:   word = c.idle_to;
            CSR_RHY_WIN:   word = c.rhy_win;
            CSR_WARMUP:    word = {8'($urandom), c.warmup};
            CSR_RUN_CAD:   word = {8'($urandom), c.run_cad};
            default:       word = c.coef;
         endcase
         csr_we    <= 1'b1;
         csr_addr  <= csr_idx_type'(i);
         csr_wdata <= word;
         @(posedge clock);
      end
      csr_we <= 1'b0;
      tuning = c;
   endtask

   function automatic logic [15:0] pick_reg(input int lo_ext, input int hi_ext,
                                            input int typ_lo, input int typ_hi);
      int r;
      r = $urandom_range(99);
      if (r < 15)
         return 16'(lo_ext);
      if (r < 30)
         return 16'(hi_ext);
      return 16'($urandom_range(typ_hi, typ_lo));
   endfunction

   function automatic cfg_type rand_tuning();
      cfg_type c;
      c.step_thr = pick_reg(0, 65535, 400, 3000);
      c.rel_thr  = pick_reg(0, 65535, 100, 1500);
      c.min_int  = pick_reg(0, 65535, 100, 500);
      c.idle_to  = pick_reg(0, 65535, 1000, 4000);
      c.rhy_win  = pick_reg(0, 65535, 600, 2500);
      c.warmup   = 8'(pick_reg(0, 255, 1, 6));   // zero: every rhythmic step counts singly
      c.run_cad  = 8'(pick_reg(0, 255, 60, 200));
      c.coef     = pick_reg(0, 65535, 1000, 20000);
      return c;
   endfunction

   function automatic logic [15:0] jitter(input int span);
      return 16'(int'($urandom_range(2 * span)) - span);
   endfunction

   // one random word: mostly gait, with clears, noise, pauses and wraps
   task automatic send_random(input logic dense);
      int          r, lift, z;
      int unsigned gap;
      logic [15:0] ax, ay, az;
      logic        clr;
      clr = 1'b0;
      r   = dense ? 99 : $urandom_range(99);
      ax  = jitter(300);
      ay  = jitter(300);
      if (r < 3) begin
         clr = 1'b1;
         ax  = 16'($urandom);
         ay  = 16'($urandom);
         az  = 16'($urandom);
         send_word(clr, ax, ay, az, $urandom, 1'b0, '0);
      end else if (r < 10) begin
         send_word(clr, 16'($urandom), 16'($urandom), 16'($urandom), $urandom, 1'b0, '0);
      end else begin
         if (r < 13) begin
            // long pause: the detector should drop to idle
            walk_ms    += $urandom_range(70000, 2000);
            gait_period = $urandom_range(1400, 200);
            gait_lift   = $urandom_range(12000, 1000);
         end else if (r < 14) begin
            walk_ms = 32'hFFFF_FFFF - $urandom_range(5000);
         end
         if (dense) begin
            // peak and rest alternate, two words per step
            dense_peak = !dense_peak;
            gap        = $urandom_range(400, 25);
            walk_ms   += gap;
            lift       = dense_peak ? 6000 : 0;
         end else begin
            gap         = $urandom_range(25, 15);
            walk_ms    += gap;
            gait_phase += gap;
            if (gait_phase >= gait_period) begin
               gait_phase -= gait_period;
               if ($urandom_range(9) == 0)
                  gait_period = $urandom_range(1400, 200);
            end
            lift = (gait_phase < 80) ? gait_lift : 0;
         end
         z  = int'(MAG_ONE_G) + lift + int'($signed(jitter(150)));
         az = $urandom_range(1) ? 16'(z) : 16'(-z);
         send_word(clr, ax, ay, az, walk_ms, 1'b0, '0);
      end
   endtask

   // ---------------------------------------------------------------------
   // Result side
   // ---------------------------------------------------------------------
   always @(posedge clock)
      rsp_tready <= ($urandom_range(99) >= recv_stall_pct);

   function automatic void note_error(input string what, input logic [31:0] want,
                                      input logic [31:0] got);
      error_count++;
      if (error_count <= MAX_REPORTS)
         $display("%0t: %s expected 0x%0h, got 0x%0h", $time, what, want, got);
   endfunction

   // sampled mid-cycle: the word moves at the next rising edge
   always @(negedge clock) begin : check_words
      rsp_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_type'(rsp_tdata[$bits(rsp_type)-1:0]);
         if (due_words.size() == 0) begin
            note_error("result word with none owed", '0, rsp_tdata[31:0]);
         end else begin
            want = due_words.pop_front();
            if (got.total !== want.total)
               note_error("total_steps", want.total, got.total);
            if (got.cadence !== want.cadence)
               note_error("cadence", 32'(want.cadence), 32'(got.cadence));
            if (got.motion !== want.motion)
               note_error("motion_class", 32'(want.motion), 32'(got.motion));
            if (got.step_seen !== want.step_seen)
               note_error("step_seen", 32'(want.step_seen), 32'(got.step_seen));
            if (rsp_tdata[RSP_DATA_W-1:$bits(rsp_type)] !== '0)
               note_error("pad bits", '0, 32'(rsp_tdata[RSP_DATA_W-1:$bits(rsp_type)]));
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= LIMIT_CYC) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // Directed plan
   // ---------------------------------------------------------------------
   function automatic plan_row_t word_row(input logic clr, input logic [15:0] ax,
                                          input logic [15:0] ay, input logic [15:0] az,
                                          input logic [31:0] tms);
      plan_row_t p;
      p      = '0;
      p.kind = ROW_WORD;
      p.clr  = clr;
      p.ax   = ax;
      p.ay   = ay;
      p.az   = az;
      p.tms  = tms;
      return p;
   endfunction

   function automatic plan_row_t known_row(input logic clr, input logic [15:0] az,
                                           input logic [31:0] tms, input logic [31:0] tot,
                                           input motion_type mo, input logic seen);
      plan_row_t p;
      p                = word_row(clr, clr ? 16'h7FFF : 16'd0, clr ? 16'h8000 : 16'd0,
                                  az, tms);
      p.typed          = 1'b1;
      p.want.total     = tot;
      p.want.cadence   = '0;
      p.want.motion    = mo;
      p.want.step_seen = seen;
      return p;
   endfunction

   function automatic plan_row_t tune_row(input csr_idx_type sel, input logic [15:0] val);
      plan_row_t p;
      p         = '0;
      p.kind    = ROW_TUNE;
      p.reg_sel = sel;
      p.reg_val = val;
      return p;
   endfunction

   initial begin : stimulus
      cfg_type nt;
      reset_tracker();

      // at rest on the reset tuning: nothing moves
      plan.push_back(known_row(1'b0, 16'd4096, 32'd0, 32'd0, MOTION_STATIONARY, 1'b0));
      // most negative vector: first step, no interval gate, not rhythmic
      plan.push_back(known_row(1'b0, 16'h8000, 32'd10, 32'd0, MOTION_ACTIVE, 1'b1));
      plan[$].ax = 16'h8000;
      plan[$].ay = 16'h8000;
      // most positive vector while disarmed
      plan.push_back(word_row(1'b0, 16'h7FFF, 16'h7FFF, 16'h7FFF, 32'd20));
      plan.push_back(word_row(1'b0, 16'd0, 16'd0, 16'd0, 32'd400));        // rearm
      plan.push_back(word_row(1'b0, 16'd0, 16'd0, 16'h7FFF, 32'd800));     // warm-up credit
      plan.push_back(word_row(1'b0, 16'd0, 16'd0, 16'd4096, 32'd820));
      plan.push_back(word_row(1'b0, 16'd0, 16'd0, 16'h7FFF, 32'd1000));    // too soon
      plan.push_back(word_row(1'b0, 16'd0, 16'd0, 16'h7FFF, 32'd1300));    // walking
      plan.push_back(word_row(1'b0, 16'd0, 16'd0, 16'd4096, 32'd1320));
      plan.push_back(word_row(1'b0, 16'd0, 16'd0, 16'h7FFF, 32'd1720));    // faster, still walking
      plan.push_back(word_row(1'b0, 16'd0, 16'd0, 16'd4096, 32'd9000));    // idle timeout
      // clear with junk in the other fields
      plan.push_back(known_row(1'b1, 16'hFFFF, 32'hFFFF_FFFF, 32'd0, MOTION_STATIONARY,
                               1'b0));
      plan.push_back(known_row(1'b0, 16'd4096, 32'hFFFF_FE00, 32'd0, MOTION_STATIONARY,
                               1'b0));
      plan.push_back(known_row(1'b0, 16'h7FFF, 32'hFFFF_FF00, 32'd0, MOTION_ACTIVE, 1'b1));
      plan.push_back(word_row(1'b0, 16'd0, 16'd0, 16'd0, 32'hFFFF_FF80));
      plan.push_back(word_row(1'b0, 16'd0, 16'd0, 16'h7FFF, 32'h0000_0100)); // across wrap
      // no minimum interval: a second step at the same ms gives cadence zero
      plan.push_back(tune_row(CSR_MIN_INT, 16'd0));
      plan.push_back(word_row(1'b0, 16'd0, 16'd0, 16'd0, 32'h0000_0100));
      plan.push_back(word_row(1'b0, 16'd0, 16'd0, 16'h7FFF, 32'h0000_0100));
      plan.push_back(word_row(1'b0, 16'd0, 16'd0, 16'd0, 32'h0000_0101));
      plan.push_back(word_row(1'b0, 16'd0, 16'd0, 16'h7FFF, 32'h0000_0150)); // cadence caps
      // warm-up of zero: every rhythmic step counts once
      plan.push_back(tune_row(CSR_WARMUP, 16'd0));
      plan.push_back(known_row(1'b1, 16'h1234, 32'd5, 32'd0, MOTION_STATIONARY, 1'b0));
      plan.push_back(known_row(1'b0, 16'h8000, 32'd100, 32'd0, MOTION_ACTIVE, 1'b1));
      plan.push_back(word_row(1'b0, 16'd0, 16'd0, 16'd0, 32'd200));
      plan.push_back(word_row(1'b0, 16'h8000, 16'd0, 16'd0, 32'd600));

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      foreach (plan[i]) begin
         if (plan[i].kind == ROW_TUNE) begin
            wait_idle();
            nt = tuning;
            case (plan[i].reg_sel)
               CSR_STEP_THR: nt.step_thr = plan[i].reg_val;
               CSR_REL_THR:  nt.rel_thr  = plan[i].reg_val;
               CSR_MIN_INT:  nt.min_int  = plan[i].reg_val;
               CSR_IDLE_TO:  nt.idle_to  = plan[i].reg_val;
               CSR_RHY_WIN:  nt.rhy_win  = plan[i].reg_val;
               CSR_WARMUP:   nt.warmup   = plan[i].reg_val[7:0];
               CSR_RUN_CAD:  nt.run_cad  = plan[i].reg_val[7:0];
               default:      nt.coef     = plan[i].reg_val;
            endcase
            load_tuning(nt);
         end else begin
            send_word(plan[i].clr, plan[i].ax, plan[i].ay, plan[i].az, plan[i].tms,
                      plan[i].typed, plan[i].want);
         end
      end

      // random blocks; the sender drains before each one
      for (int blk = 0; blk < N_BLOCKS; blk++) begin
         wait_idle();
         case (blk % 4)
            0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1:       begin send_idle_pct = 71; recv_stall_pct = 0;  end
            2:       begin send_idle_pct = 0;  recv_stall_pct = 71; end
            default: begin send_idle_pct = 31; recv_stall_pct = 31; end
         endcase
         if (blk == 3) begin
            // dense gait that never times out: drives the run into saturation
            nt         = CFG_RESET;
            nt.min_int = 16'd40;
            nt.idle_to = 16'hFFFF;
            nt.rhy_win = 16'hFFFF;
            nt.warmup  = 8'd255;
            nt.run_cad = 8'($urandom_range(255));
            load_tuning(nt);
         end else if (blk < 3 || blk > 8) begin
            load_tuning(rand_tuning());
         end
         for (int k = 0; k < BLOCK_WORDS; k++)
            send_random(blk >= 3 && blk <= 8);
      end

      req_tvalid <= 1'b0;
      while (due_words.size() != 0)
         @(posedge clock);
      repeat (60) @(posedge clock);
      if (error_count == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule

### filelist.f
src/psd_pkg.sv
src/psd_useq.sv
src/psd_dpath.sv
src/pedometer_step_detector.sv
bench/testbench.sv
